// ----- rtl/core/cshoe_pkg.sv -----
// Shared types and constants for the card shoe shuffle/deal unit.
package cshoe_pkg;

  localparam int unsigned CardsPerDeck = 52;
  localparam int unsigned RankCount    = 13;
  localparam int unsigned CountW       = 10;
  localparam int unsigned WordW        = 32;
  localparam int unsigned DeckW        = 4;
  localparam int unsigned ApbAddrW     = 2;
  localparam int unsigned ApbDataW     = 32;

  localparam logic [ApbAddrW-1:0] AddrDeckCount = 2'd0;
  localparam logic [DeckW-1:0]    DeckCountRst  = 4'd1;
  localparam logic [3:0]          RankLast      = 4'(RankCount - 1);

  typedef enum logic [1:0] {
    OP_BUILD   = 2'd0,
    OP_SHUFFLE = 2'd1,
    OP_DEAL    = 2'd2,
    OP_READ    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_DONE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RD_NONE    = 3'd0,
    RD_POS     = 3'd1,
    RD_PARTNER = 3'd2,
    RD_TOP     = 3'd3,
    RD_INDEX   = 3'd4
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE    = 2'd0,
    WR_BUILD   = 2'd1,
    WR_POS     = 2'd2,
    WR_PARTNER = 2'd3
  } wr_sel_e;

  typedef struct packed {
    logic [1:0] suit;
    logic [3:0] rank;
  } card_t;

  typedef struct packed {
    logic    accept;
    logic    build_init;
    logic    div_start;
    logic    latch_partner;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    cap_tmp;
    logic    sp_inc;
    logic    rc_dec;
    logic    set_status;
    status_e status;
    logic    cap_card;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    opcode_e opcode;
    logic    no_decks;
    logic    shuffle_done;
    logic    shoe_empty;
    logic    index_oob;
    logic    build_last;
    logic    div_done;
  } stat_t;

endpackage

// ----- rtl/core/cshoe_if.sv -----
// Request and response channel interfaces of the card shoe unit.
interface cshoe_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] random_word;
  logic [9:0]  card_index;

  modport source (output valid, opcode, random_word, card_index, input ready);
  modport sink (input valid, opcode, random_word, card_index, output ready);
endinterface

interface cshoe_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] suit;
  logic [3:0] rank;
  logic [1:0] status;
  logic [9:0] cards_left;

  modport source (output valid, suit, rank, status, cards_left, input ready);
  modport sink (input valid, suit, rank, status, cards_left, output ready);
endinterface

// ----- rtl/core/cshoe_mod.sv -----
// Bit-serial remainder unit: one dividend bit per cycle.
module cshoe_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cshoe_pkg::WordW-1:0]   dividend_i,
  input  logic [cshoe_pkg::CountW-1:0]  divisor_i,
  output logic                          done_o,
  output logic [cshoe_pkg::CountW-1:0]  rem_o
);

  localparam int unsigned CntW = $clog2(cshoe_pkg::WordW);

  logic                         busy_q;
  logic                         done_q;
  logic [CntW-1:0]              cnt_q;
  logic [cshoe_pkg::WordW-1:0]  dvd_q;
  logic [cshoe_pkg::CountW-1:0] dvs_q;
  logic [cshoe_pkg::CountW-1:0] rem_q;
  logic [cshoe_pkg::CountW:0]   shifted;
  logic [cshoe_pkg::CountW:0]   trial;
  logic                         fits;

  assign shifted = {rem_q, dvd_q[cshoe_pkg::WordW-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(cshoe_pkg::WordW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[cshoe_pkg::WordW-2:0], 1'b0};
      rem_q <= fits ? trial[cshoe_pkg::CountW-1:0] : shifted[cshoe_pkg::CountW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/core/cshoe_dp.sv -----
// Datapath: card store, counts, build counters, swap and result registers.
module cshoe_dp #(
  parameter int unsigned DECK_LIMIT = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cshoe_pkg::DeckW-1:0]   deck_count_i,
  input  logic [1:0]                    opcode_i,
  input  logic [cshoe_pkg::WordW-1:0]   random_word_i,
  input  logic [cshoe_pkg::CountW-1:0]  card_index_i,
  input  cshoe_pkg::cmd_t               cmd_i,
  output cshoe_pkg::stat_t              stat_o,
  output logic [1:0]                    suit_o,
  output logic [3:0]                    rank_o,
  output logic [1:0]                    status_o,
  output logic [cshoe_pkg::CountW-1:0]  cards_left_o
);

  localparam int unsigned StoreDepth = DECK_LIMIT * cshoe_pkg::CardsPerDeck;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned DecksW     = cshoe_pkg::DeckW + 1;

  cshoe_pkg::card_t   mem [StoreDepth];

  cshoe_pkg::opcode_e op_q;
  logic [cshoe_pkg::WordW-1:0]  word_q;
  logic [cshoe_pkg::CountW-1:0] index_q;
  logic [cshoe_pkg::CountW-1:0] total_q;
  logic [cshoe_pkg::CountW-1:0] rc_q;
  logic [cshoe_pkg::CountW-1:0] sp_q;
  logic [AddrW-1:0]             pos_q;
  logic [1:0]                   suit_ctr_q;
  logic [3:0]                   rank_ctr_q;
  logic [AddrW-1:0]             partner_q;
  cshoe_pkg::card_t   tmp_q;
  cshoe_pkg::card_t   rdata_q;
  cshoe_pkg::card_t   res_card_q;
  cshoe_pkg::status_e res_status_q;
  cshoe_pkg::card_t   out_card_q;
  cshoe_pkg::status_e out_status_q;
  logic [cshoe_pkg::CountW-1:0] out_left_q;

  logic [DecksW-1:0]            decks_raw;
  logic [DecksW-1:0]            decks_sat;
  logic [cshoe_pkg::CountW-1:0] total_d;
  logic [cshoe_pkg::CountW-1:0] span;
  logic [cshoe_pkg::CountW-1:0] rem;
  logic [cshoe_pkg::CountW-1:0] partner_d;
  logic [cshoe_pkg::CountW-1:0] rc_m1;
  logic [cshoe_pkg::CountW-1:0] total_m1;
  logic                         div_done;
  logic                         rd_en;
  logic [AddrW-1:0]             rd_addr;
  logic                         wr_en;
  logic [AddrW-1:0]             wr_addr;
  cshoe_pkg::card_t             wr_card;

  assign decks_raw = DecksW'(deck_count_i);
  assign decks_sat = (decks_raw > DecksW'(DECK_LIMIT)) ? DecksW'(DECK_LIMIT) : decks_raw;
  assign total_d   = cshoe_pkg::CountW'(32'(decks_sat) * cshoe_pkg::CardsPerDeck);
  assign span      = rc_q - sp_q;
  assign partner_d = sp_q + rem;
  assign rc_m1     = rc_q - 1'b1;
  assign total_m1  = total_q - 1'b1;

  cshoe_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (word_q),
    .divisor_i  (span),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  always_comb begin
    stat_o.opcode       = op_q;
    stat_o.no_decks     = (total_q == '0);
    stat_o.shuffle_done = (sp_q >= rc_q);
    stat_o.shoe_empty   = (rc_q == '0);
    stat_o.index_oob    = (index_q >= rc_q);
    stat_o.build_last   = (cshoe_pkg::CountW'(pos_q) == total_m1);
    stat_o.div_done     = div_done;
  end

  always_comb begin
    rd_en   = (cmd_i.rd_sel != cshoe_pkg::RD_NONE);
    rd_addr = '0;
    unique case (cmd_i.rd_sel)
      cshoe_pkg::RD_POS:     rd_addr = sp_q[AddrW-1:0];
      cshoe_pkg::RD_PARTNER: rd_addr = partner_q;
      cshoe_pkg::RD_TOP:     rd_addr = rc_m1[AddrW-1:0];
      cshoe_pkg::RD_INDEX:   rd_addr = index_q[AddrW-1:0];
      default:               rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = (cmd_i.wr_sel != cshoe_pkg::WR_NONE);
    wr_addr = '0;
    wr_card = '0;
    unique case (cmd_i.wr_sel)
      cshoe_pkg::WR_BUILD: begin
        wr_addr = pos_q;
        wr_card = '{suit: suit_ctr_q, rank: rank_ctr_q};
      end
      cshoe_pkg::WR_POS: begin
        wr_addr = sp_q[AddrW-1:0];
        wr_card = rdata_q;
      end
      cshoe_pkg::WR_PARTNER: begin
        wr_addr = partner_q;
        wr_card = tmp_q;
      end
      default: begin
        wr_addr = '0;
        wr_card = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_card;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= '0;
      sp_q <= '0;
    end else begin
      if (cmd_i.build_init) begin
        rc_q <= total_q;
        sp_q <= '0;
      end else begin
        if (cmd_i.rc_dec) begin
          rc_q <= rc_m1;
        end
        if (cmd_i.sp_inc) begin
          sp_q <= sp_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q         <= cshoe_pkg::opcode_e'(opcode_i);
      word_q       <= random_word_i;
      index_q      <= card_index_i;
      total_q      <= total_d;
      res_card_q   <= '0;
      res_status_q <= cshoe_pkg::STAT_OK;
    end else begin
      if (cmd_i.set_status) begin
        res_status_q <= cmd_i.status;
      end
      if (cmd_i.cap_card) begin
        res_card_q <= rdata_q;
      end
    end
    if (cmd_i.build_init) begin
      pos_q      <= '0;
      suit_ctr_q <= '0;
      rank_ctr_q <= '0;
    end else if (cmd_i.wr_sel == cshoe_pkg::WR_BUILD) begin
      pos_q <= pos_q + 1'b1;
      if (rank_ctr_q == cshoe_pkg::RankLast) begin
        rank_ctr_q <= '0;
        suit_ctr_q <= suit_ctr_q + 1'b1;
      end else begin
        rank_ctr_q <= rank_ctr_q + 1'b1;
      end
    end
    if (cmd_i.latch_partner) begin
      partner_q <= partner_d[AddrW-1:0];
    end
    if (cmd_i.cap_tmp) begin
      tmp_q <= rdata_q;
    end
    if (cmd_i.load_out) begin
      out_card_q   <= res_card_q;
      out_status_q <= res_status_q;
      out_left_q   <= rc_q;
    end
  end

  assign suit_o       = out_card_q.suit;
  assign rank_o       = out_card_q.rank;
  assign status_o     = out_status_q;
  assign cards_left_o = out_left_q;

endmodule

// ----- rtl/core/cshoe_ctrl.sv -----
// Controller: sequences build, shuffle step, deal and read requests.
module cshoe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  cshoe_pkg::stat_t stat_i,
  output cshoe_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_BUILD  = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_RD_P   = 4'd4;
  localparam logic [3:0] S_RD_Q   = 4'd5;
  localparam logic [3:0] S_WR_P   = 4'd6;
  localparam logic [3:0] S_WR_Q   = 4'd7;
  localparam logic [3:0] S_CAP    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_q;
  logic [3:0] state_d;
  logic       out_valid_q;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.opcode)
          cshoe_pkg::OP_BUILD: begin
            cmd_o.build_init = 1'b1;
            state_d = stat_i.no_decks ? S_DONE : S_BUILD;
          end
          cshoe_pkg::OP_SHUFFLE: begin
            if (stat_i.shuffle_done) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = cshoe_pkg::STAT_DONE;
              state_d          = S_DONE;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
          cshoe_pkg::OP_DEAL: begin
            if (stat_i.shoe_empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = cshoe_pkg::STAT_EMPTY;
              state_d          = S_DONE;
            end else begin
              cmd_o.rd_sel = cshoe_pkg::RD_TOP;
              cmd_o.rc_dec = 1'b1;
              state_d      = S_CAP;
            end
          end
          cshoe_pkg::OP_READ: begin
            if (stat_i.index_oob) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = cshoe_pkg::STAT_RANGE;
              state_d          = S_DONE;
            end else begin
              cmd_o.rd_sel = cshoe_pkg::RD_INDEX;
              state_d      = S_CAP;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_BUILD: begin
        cmd_o.wr_sel = cshoe_pkg::WR_BUILD;
        if (stat_i.build_last) begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.latch_partner = 1'b1;
          state_d             = S_RD_P;
        end
      end
      S_RD_P: begin
        cmd_o.rd_sel = cshoe_pkg::RD_POS;
        state_d      = S_RD_Q;
      end
      S_RD_Q: begin
        cmd_o.rd_sel  = cshoe_pkg::RD_PARTNER;
        cmd_o.cap_tmp = 1'b1;
        state_d       = S_WR_P;
      end
      S_WR_P: begin
        cmd_o.wr_sel = cshoe_pkg::WR_POS;
        state_d      = S_WR_Q;
      end
      S_WR_Q: begin
        cmd_o.wr_sel = cshoe_pkg::WR_PARTNER;
        cmd_o.sp_inc = 1'b1;
        state_d      = S_DONE;
      end
      S_CAP: begin
        cmd_o.cap_card = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/card_shoe_shuffle_deal_unit.sv -----
// Top level of the card shoe unit: channels, config register, controller and datapath.
//
// Usage: requests arrive on req_i (valid/ready), one result per request leaves
// on rsp_o (valid/ready). Opcodes: build shoe, one Fisher-Yates shuffle step
// driven by random_word, deal top card, read card at card_index.
// deck_count is written over the APB port (address 0), by the user only while the
// unit is idle, which the unit does not enforce; values above DECK_LIMIT saturate at
// the next build. Steps from request accept to result valid:
//   build:   decks*52 cards, one card store write per cycle.
//   shuffle: bit-serial remainder unit, then two reads and two writes on the card store.
//   deal, read: one registered card store read.
//   Error cases (empty shoe, index out of range, shuffle complete): status only.
// One request is in work at a time; the next is taken the cycle after the
// result loads into the output register.
// Reset clears the cards-left count, the shuffle position and the handshake
// state and sets deck_count to 1; the card store holds no reset value.
// If the receiver stalls, the result holds in the output register and a
// finished request waits until that register frees.
module card_shoe_shuffle_deal_unit #(
  parameter int unsigned DECK_LIMIT = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  cshoe_req_if.sink                        req_i,
  cshoe_rsp_if.source                      rsp_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cshoe_pkg::ApbAddrW-1:0]   paddr,
  input  logic [cshoe_pkg::ApbDataW-1:0]   pwdata,
  output logic [cshoe_pkg::ApbDataW-1:0]   prdata,
  output logic                             pready
);

  logic [cshoe_pkg::DeckW-1:0] deck_count_q;
  logic                        cfg_wr;
  cshoe_pkg::cmd_t             cmd;
  cshoe_pkg::stat_t            stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == cshoe_pkg::AddrDeckCount);
  assign prdata = (paddr == cshoe_pkg::AddrDeckCount)
                ? cshoe_pkg::ApbDataW'(deck_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deck_count_q <= cshoe_pkg::DeckCountRst;
    end else if (cfg_wr) begin
      deck_count_q <= pwdata[cshoe_pkg::DeckW-1:0];
    end
  end

  cshoe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cshoe_dp #(
    .DECK_LIMIT (DECK_LIMIT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .deck_count_i  (deck_count_q),
    .opcode_i      (req_i.opcode),
    .random_word_i (req_i.random_word),
    .card_index_i  (req_i.card_index),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .suit_o        (rsp_o.suit),
    .rank_o        (rsp_o.rank),
    .status_o      (rsp_o.status),
    .cards_left_o  (rsp_o.cards_left)
  );

endmodule

// ----- rtl/core/cshoe_chk.sv -----
// Port-level checker for the card shoe unit and its bind to the top level.
module cshoe_chk #(
  parameter int unsigned DECK_LIMIT = 10
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [1:0]                    rsp_suit_i,
  input logic [3:0]                    rsp_rank_i,
  input logic [1:0]                    rsp_status_i,
  input logic [cshoe_pkg::CountW-1:0]  rsp_cards_left_i
);

  localparam logic [cshoe_pkg::CountW-1:0] LeftMax =
    cshoe_pkg::CountW'(DECK_LIMIT * cshoe_pkg::CardsPerDeck);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_suit_i)
      && $stable(rsp_rank_i) && $stable(rsp_status_i) && $stable(rsp_cards_left_i))
    else $error("response changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("second request taken while one is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != cshoe_pkg::STAT_OK) |-> rsp_suit_i == 2'd0
      && rsp_rank_i == 4'd0)
    else $error("card fields set on a failed request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_rank_i <= cshoe_pkg::RankLast)
    else $error("rank out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_cards_left_i <= LeftMax)
    else $error("cards left above shoe capacity");

endmodule

bind card_shoe_shuffle_deal_unit cshoe_chk #(
  .DECK_LIMIT (DECK_LIMIT)
) u_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_suit_i       (rsp_o.suit),
  .rsp_rank_i       (rsp_o.rank),
  .rsp_status_i     (rsp_o.status),
  .rsp_cards_left_i (rsp_o.cards_left)
);
